>>> rtl/binary_image_thinning_core_defines.svh
// Assertion macros used by the checker of the thinning core.
`ifndef BINARY_IMAGE_THINNING_CORE_DEFINES_SVH
`define BINARY_IMAGE_THINNING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define BITC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thinning core check failed in %m");

// Next-cycle implication, sampled on clk and held off during reset.
`define BITC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thinning core check failed in %m");

`endif

>>> rtl/bitc_pkg.sv
// Package of the thinning core: sizes, codes, command/status types and pixel functions.
`timescale 1ns / 1ps

package bitc_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int ROW_W      = 64;
    localparam int ROWNUM_W   = 6;
    localparam int ITER_W     = 8;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int COL_CAP = (MAX_WIDTH < ROW_W) ? MAX_WIDTH : ROW_W;
    localparam int ROW_CAP = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
    localparam int ADDR_W  = $clog2(ROW_CAP);

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = CFG_IDX_W'(2);

    localparam logic [ITER_W-1:0] ITER_MAX = '1;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [ITER_W-1:0] iter_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic  load_wr;     // store the incoming row
        addr_t load_addr;
        logic  rd_en;       // read a stored row
        addr_t rd_addr;
        logic  prime;       // fill the window with the first row
        logic  row_step;    // thin one row, write it back, slide the window
        addr_t row_addr;
        logic  next_valid;  // row below lies inside the image
        logic  second;      // second subpass product tests
        logic  clr_any;     // start a new subpass
        logic  out_load;    // capture a result row
        logic  out_final;
        iter_t iters;
    } bitc_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        dim_t  height;      // effective image height
        iter_t limit;
        logic  any_mark;    // current subpass deleted at least one pixel
    } bitc_stat_t;

    function automatic dim_t clamp_dim(dim_t v, int cap);
        dim_t r;
        r = v;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (v > dim_t'(cap))
        begin
            r = dim_t'(cap);
        end
        return r;
    endfunction

    function automatic row_t width_mask(dim_t w);
        row_t m;
        for (int j = 0; j < ROW_W; j++)
        begin
            m[j] = (dim_t'(j) < w);
        end
        return m;
    endfunction

    // n[0..7] = p2..p9 clockwise from the pixel above
    function automatic logic zs_mark(logic p1, logic [7:0] n, logic second);
        logic [3:0] sum;
        logic [3:0] trans;
        logic       prod_ok;
        sum   = '0;
        trans = '0;
        for (int k = 0; k < 8; k++)
        begin
            sum = sum + 4'(n[k]);
            if (!n[k] && n[(k + 1) % 8])
            begin
                trans = trans + 4'd1;
            end
        end
        if (second)
        begin
            prod_ok = !(n[0] & n[2] & n[6]) && !(n[0] & n[4] & n[6]);
        end
        else
        begin
            prod_ok = !(n[0] & n[2] & n[4]) && !(n[2] & n[4] & n[6]);
        end
        return p1 && (sum >= 4'd2) && (sum <= 4'd6) && (trans == 4'd1) && prod_ok;
    endfunction

endpackage

>>> rtl/bitc_channels.sv
// Valid/ready channel interfaces of the thinning core: row input and result output.
`timescale 1ns / 1ps

interface bitc_row_if;
    logic                       valid;
    logic                       ready;
    logic [bitc_pkg::ROW_W-1:0] row_pixels;

    modport source (output valid, output row_pixels, input ready);
    modport sink   (input valid, input row_pixels, output ready);
endinterface

interface bitc_res_if;
    logic                          valid;
    logic                          ready;
    logic [bitc_pkg::ROW_W-1:0]    thinned_row;
    logic [bitc_pkg::ROWNUM_W-1:0] row_number;
    logic [bitc_pkg::ITER_W-1:0]   iterations_run;
    logic                          final_row;

    modport source (output valid, output thinned_row, output row_number,
                    output iterations_run, output final_row, input ready);
    modport sink   (input valid, input thinned_row, input row_number,
                    input iterations_run, input final_row, output ready);
endinterface

>>> rtl/bitc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bitc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bitc_ctrl.sv
// Sequencer of the thinning core: load, subpass sweeps, iteration count and emit.
`timescale 1ns / 1ps

module bitc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bitc_pkg::bitc_stat_t stat,
    output bitc_pkg::bitc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_ITER,
        S_SP_START,
        S_SP_PRIME,
        S_SP_ROW,
        S_SP_END,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_WAIT
    } state_t;

    state_t               state_reg, state_next;
    bitc_pkg::dim_t       loaded_reg, loaded_next;
    bitc_pkg::addr_t      row_reg, row_next;
    bitc_pkg::iter_t      iter_reg, iter_next;
    logic                 second_reg, second_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 last_row;
    logic                 more_below;

    // Row counter against the height: last row and whether a row lies below
    assign last_row   = (bitc_pkg::dim_t'(row_reg) + bitc_pkg::dim_t'(1)) >= stat.height;
    assign more_below = !last_row;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        row_next       = row_reg;
        iter_next      = iter_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.second     = second_reg;
        cmd.row_addr   = row_reg;
        cmd.iters      = iter_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load_wr   = 1'b1;
                    cmd.load_addr = loaded_reg[bitc_pkg::ADDR_W-1:0];
                    if ((loaded_reg + bitc_pkg::dim_t'(1)) >= stat.height)
                    begin
                        loaded_next = '0;
                        iter_next   = '0;
                        state_next  = S_ITER;
                    end
                    else
                    begin
                        loaded_next = loaded_reg + bitc_pkg::dim_t'(1);
                    end
                end
            end
            S_ITER:
            begin
                if ((stat.limit != '0) && (iter_reg >= stat.limit))
                begin
                    row_next   = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    iter_next   = (iter_reg == bitc_pkg::ITER_MAX) ? iter_reg
                                : iter_reg + bitc_pkg::iter_t'(1);
                    second_next = 1'b0;
                    state_next  = S_SP_START;
                end
            end
            S_SP_START:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = '0;
                cmd.clr_any = 1'b1;
                state_next  = S_SP_PRIME;
            end
            S_SP_PRIME:
            begin
                cmd.prime   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = bitc_pkg::addr_t'(1);
                row_next    = '0;
                state_next  = S_SP_ROW;
            end
            S_SP_ROW:
            begin
                cmd.row_step   = 1'b1;
                cmd.next_valid = more_below;
                cmd.rd_en      = 1'b1;
                cmd.rd_addr    = row_reg + bitc_pkg::addr_t'(2);
                if (last_row)
                begin
                    state_next = S_SP_END;
                end
                else
                begin
                    row_next = row_reg + bitc_pkg::addr_t'(1);
                end
            end
            S_SP_END:
            begin
                if (!stat.any_mark)
                begin
                    row_next   = '0;
                    state_next = S_EMIT_RD;
                end
                else if (!second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = S_SP_START;
                end
                else
                begin
                    state_next = S_ITER;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = row_reg;
                state_next  = S_EMIT_CAP;
            end
            S_EMIT_CAP:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_final  = last_row;
                out_valid_next = 1'b1;
                state_next     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_row)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        row_next   = row_reg + bitc_pkg::addr_t'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            row_reg       <= '0;
            iter_reg      <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            row_reg       <= row_next;
            iter_reg      <= iter_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/bitc_datapath.sv
// Datapath of the thinning core: registers, row store, three-row window and marking lanes.
`timescale 1ns / 1ps

module bitc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bitc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bitc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  bitc_pkg::row_t                      row_pixels,
    input  bitc_pkg::bitc_cmd_t                 cmd,
    output bitc_pkg::bitc_stat_t                stat,
    output bitc_pkg::row_t                      thinned_row,
    output logic [bitc_pkg::ROWNUM_W-1:0]       row_number,
    output bitc_pkg::iter_t                     iterations_run,
    output logic                                final_row
);

    bitc_pkg::dim_t  cfg_width_reg;
    bitc_pkg::dim_t  cfg_height_reg;
    bitc_pkg::iter_t cfg_limit_reg;

    bitc_pkg::row_t  prev_reg;
    bitc_pkg::row_t  cur_reg;
    logic            any_reg;

    bitc_pkg::row_t  out_row_reg;
    logic [bitc_pkg::ROWNUM_W-1:0] out_num_reg;
    bitc_pkg::iter_t out_iter_reg;
    logic            out_final_reg;

    bitc_pkg::row_t  mask;
    bitc_pkg::row_t  rd_row;
    bitc_pkg::row_t  next_row;
    bitc_pkg::row_t  marks;
    logic [bitc_pkg::ROW_W+1:0] pe, ce, ne;
    logic [7:0]      nb;

    logic            wr_en;
    bitc_pkg::addr_t wr_addr;
    bitc_pkg::row_t  wr_data;
    bitc_pkg::row_t  ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= bitc_pkg::dim_t'(64);
            cfg_height_reg <= bitc_pkg::dim_t'(64);
            cfg_limit_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bitc_pkg::REG_WIDTH:  cfg_width_reg  <= cfg_data[bitc_pkg::DIM_W-1:0];
                bitc_pkg::REG_HEIGHT: cfg_height_reg <= cfg_data[bitc_pkg::DIM_W-1:0];
                bitc_pkg::REG_LIMIT:  cfg_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mask = bitc_pkg::width_mask(bitc_pkg::clamp_dim(cfg_width_reg, bitc_pkg::COL_CAP));

    assign stat.height   = bitc_pkg::clamp_dim(cfg_height_reg, bitc_pkg::ROW_CAP);
    assign stat.limit    = cfg_limit_reg;
    assign stat.any_mark = any_reg;

    // Columns beyond the width read as background everywhere
    assign rd_row   = ram_rdata & mask;
    assign next_row = cmd.next_valid ? rd_row : '0;

    // Pad one background column on each side of the window
    assign pe = {1'b0, prev_reg, 1'b0};
    assign ce = {1'b0, cur_reg, 1'b0};
    assign ne = {1'b0, next_row, 1'b0};

    always_comb
    begin
        nb    = '0;
        marks = '0;
        for (int c = 0; c < bitc_pkg::ROW_W; c++)
        begin
            nb = {pe[c], ce[c], ne[c], ne[c + 1], ne[c + 2], ce[c + 2], pe[c + 2], pe[c + 1]};
            marks[c] = bitc_pkg::zs_mark(cur_reg[c], nb, cmd.second);
        end
    end

    assign wr_en   = cmd.load_wr | cmd.row_step;
    assign wr_addr = cmd.load_wr ? cmd.load_addr : cmd.row_addr;
    assign wr_data = cmd.load_wr ? (row_pixels & mask) : (cur_reg & ~marks);

    bitc_ram #(
        .WIDTH (bitc_pkg::ROW_W),
        .DEPTH (bitc_pkg::ROW_CAP)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else if (cmd.clr_any)
        begin
            any_reg <= 1'b0;
        end
        else if (cmd.row_step)
        begin
            any_reg <= any_reg | (|marks);
        end
    end

    // Window and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.prime)
        begin
            prev_reg <= '0;
            cur_reg  <= rd_row;
        end
        else if (cmd.row_step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= next_row;
        end
        if (cmd.out_load)
        begin
            out_row_reg   <= rd_row;
            out_num_reg   <= bitc_pkg::ROWNUM_W'(cmd.row_addr);
            out_iter_reg  <= cmd.iters;
            out_final_reg <= cmd.out_final;
        end
    end

    assign thinned_row    = out_row_reg;
    assign row_number     = out_num_reg;
    assign iterations_run = out_iter_reg;
    assign final_row      = out_final_reg;

endmodule

>>> rtl/binary_image_thinning_core.sv
// Top level of the Zhang-Suen thinning core: sequencer, datapath and channel ports.
//
// Use of the block:
//   image    : row input channel, one 64-bit row per transfer, bit j = column j.
//   skeleton : result channel, one thinned row per transfer with its row number,
//              the iteration count and a flag on the last row.
//   cfg_*    : register writes (0 width, 1 height, 2 iteration limit); the
//              user must make them only while idle, not enforced by the block.
// Each transferred row is written straight into the row store. The
// transfer that completes the image starts thinning; image.ready stays
// low until the last result row has transferred. Thinning time is set
// by the single row store: each subpass sweeps all rows through one read
// and one write port, and each iteration adds a count check. Each result
// row is read, captured into the result register and held until the
// receiver takes it.
// A stalled receiver holds the result register; the block waits with it.
// Reset clears the sequencer and restores width 64, height 64, no limit; the
// row store is not cleared, since every row is written before it is read.
`timescale 1ns / 1ps

module binary_image_thinning_core (
    input  logic                            clk,
    input  logic                            rst_n,
    bitc_row_if.sink                        image,
    bitc_res_if.source                      skeleton,
    input  logic                            cfg_wr_en,
    input  logic [bitc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bitc_pkg::CFG_DATA_W-1:0] cfg_data
);

    bitc_pkg::bitc_cmd_t  cmd;
    bitc_pkg::bitc_stat_t stat;

    // Sequencer: owns the handshakes and every counter
    bitc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (image.valid),
        .in_ready  (image.ready),
        .out_valid (skeleton.valid),
        .out_ready (skeleton.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: registers, row store, marking window and the result register
    bitc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .row_pixels     (image.row_pixels),
        .cmd            (cmd),
        .stat           (stat),
        .thinned_row    (skeleton.thinned_row),
        .row_number     (skeleton.row_number),
        .iterations_run (skeleton.iterations_run),
        .final_row      (skeleton.final_row)
    );

endmodule

>>> rtl/bitc_checker.sv
// Port-level checker of the thinning core and its bind to the top level.
`timescale 1ns / 1ps
`include "binary_image_thinning_core_defines.svh"

module bitc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bitc_pkg::ROW_W-1:0]    out_row,
    input logic [bitc_pkg::ROWNUM_W-1:0] out_num,
    input logic                          out_final
);

    // Hold a stalled result unchanged
    `BITC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row) && $stable(out_num) && $stable(out_final))

    // Take no row while a result waits
    `BITC_ASSERT_SAME(a_no_load_during_emit, out_valid, !in_ready && (in_valid || !in_valid))

    // Rows leave in order
    `BITC_ASSERT_NEXT(a_row_order, out_valid && out_ready && !out_final, ##2 (out_valid && (out_num == bitc_pkg::ROWNUM_W'($past(out_num, 3) + 1'b1))))

    // Return to loading after the last row
    `BITC_ASSERT_NEXT(a_reload_after_final, out_valid && out_ready && out_final, in_ready && !out_valid)

endmodule

bind binary_image_thinning_core bitc_checker u_bitc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (image.valid),
    .in_ready  (image.ready),
    .out_valid (skeleton.valid),
    .out_ready (skeleton.ready),
    .out_row   (skeleton.thinned_row),
    .out_num   (skeleton.row_number),
    .out_final (skeleton.final_row)
);
